// File: hw/rtl/bytd_pkg.sv
// Package: transaction types, character constants and decoder codes for the bytea text decoder.
package bytd_pkg;

	// Input transaction: one character of the encoded string
	typedef struct packed {
		logic [7:0] in_byte;
		logic       last;
	} bytd_in_t;

	// Output transaction: one decoded byte or the end item of a string
	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_end;
		logic       error;
	} bytd_out_t;

	// Characters that steer the decode
	localparam logic [7:0] CHAR_BSL = 8'h5C;   // backslash
	localparam logic [7:0] CHAR_X   = 8'h78;   // 'x'
	localparam logic [7:0] CHAR_0   = 8'h30;
	localparam logic [7:0] CHAR_3   = 8'h33;
	localparam logic [7:0] CHAR_7   = 8'h37;
	localparam logic [7:0] CHAR_9   = 8'h39;
	localparam logic [7:0] CHAR_LA  = 8'h61;   // 'a'
	localparam logic [7:0] CHAR_LF  = 8'h66;   // 'f'
	localparam logic [7:0] CHAR_UA  = 8'h41;   // 'A'
	localparam logic [7:0] CHAR_UF  = 8'h46;   // 'F'
	localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

	// Decode mode codes
	localparam logic [1:0] MODE_FIRST = 2'd0;  // awaiting first character
	localparam logic [1:0] MODE_BSL   = 2'd1;  // first character was a backslash
	localparam logic [1:0] MODE_HEX   = 2'd2;
	localparam logic [1:0] MODE_ESC   = 2'd3;

	// Escape phase codes
	localparam logic [1:0] PH_IDLE   = 2'd0;   // no escape open
	localparam logic [1:0] PH_AFTER  = 2'd1;   // just after a backslash
	localparam logic [1:0] PH_SECOND = 2'd2;   // second character of an octal run
	localparam logic [1:0] PH_THIRD  = 2'd3;   // third character of an octal run

	// Output queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = 2;
	localparam int CNT_W      = 3;

endpackage

// File: hw/rtl/bytea_text_decoder.sv
// Top level: streaming decoder from hex or escape text format to raw bytes.
//
//  channel | dir | handshake             | payload
//  char    | in  | char_valid/char_stall | char_data (bytd_in_t: in_byte, last)
//  byte    | out | byte_valid/byte_stall | byte_data (bytd_out_t: out_byte, is_end, error)
//
// One character is taken per cycle while the input does not stall, into an input register,
// and decoded from there straight into a four-entry output queue; a character yields at
// most two results (a byte and the end item), so the input stalls only when the queue
// has fewer than two free entries.
// Reset clears the decode state, the input register valid flag and the queue pointers and count.
// A stall on the output side holds the head result and backs up into the input.
module bytea_text_decoder
	import bytd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	output logic      char_stall,
	input  bytd_in_t  char_data,
	output logic      byte_valid,
	input  logic      byte_stall,
	output bytd_out_t byte_data
);

	// Input register
	logic       valid_s1;
	bytd_in_t   data_s1;
	logic       adv;

	// Decode state
	logic [1:0] mode_q, mode_n;
	logic       pend_q, pend_n;
	logic [3:0] nval_q, nval_n;
	logic [1:0] phase_q, phase_n;
	logic       open_q, open_n;
	logic [7:0] acc_q, acc_n;
	logic       err_q, err_n;

	// Decode results
	logic       have_byte;
	logic [7:0] emit_val;
	logic       run_esc;
	logic [1:0] esc_phase;
	logic [4:0] hex_d;

	// Output queue
	bytd_out_t        fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       push_cnt;
	logic             pop;
	bytd_out_t        ent0, ent1;

	// Hex digit value with a valid flag on top
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= CHAR_0 && c <= CHAR_9) begin
			v = c - CHAR_0;
			return {1'b1, v[3:0]};
		end else if (c >= CHAR_LA && c <= CHAR_LF) begin
			v = c - CHAR_LA + HEX_ALPHA_BASE;
			return {1'b1, v[3:0]};
		end else if (c >= CHAR_UA && c <= CHAR_UF) begin
			v = c - CHAR_UA + HEX_ALPHA_BASE;
			return {1'b1, v[3:0]};
		end
		return 5'd0;
	endfunction

	// Advance the input register when the queue can absorb two results
	assign adv        = valid_s1 && (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign char_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			data_s1 <= char_data;
		end
	end

	// Decode one character against the current state
	assign hex_d = hex_digit(data_s1.in_byte);

	always_comb begin
		mode_n    = mode_q;
		pend_n    = pend_q;
		nval_n    = nval_q;
		phase_n   = phase_q;
		open_n    = open_q;
		acc_n     = acc_q;
		err_n     = err_q;
		have_byte = 1'b0;
		emit_val  = '0;
		run_esc   = 1'b0;
		esc_phase = phase_q;
		if (!err_q) begin
			unique case (mode_q)
				MODE_FIRST: begin
					if (data_s1.in_byte == CHAR_BSL) begin
						mode_n = MODE_BSL;
						if (data_s1.last) err_n = 1'b1;
					end else begin
						mode_n    = MODE_ESC;
						have_byte = 1'b1;
						emit_val  = data_s1.in_byte;
					end
				end
				MODE_BSL: begin
					if (data_s1.in_byte == CHAR_X) begin
						mode_n = MODE_HEX;
					end else begin
						mode_n    = MODE_ESC;
						run_esc   = 1'b1;
						esc_phase = PH_AFTER;
					end
				end
				MODE_HEX: begin
					if (!hex_d[4]) begin
						err_n = 1'b1;
					end else if (!pend_q) begin
						nval_n = hex_d[3:0];
						pend_n = 1'b1;
						if (data_s1.last) begin
							have_byte = 1'b1;
							emit_val  = {4'd0, hex_d[3:0]};
						end
					end else begin
						have_byte = 1'b1;
						emit_val  = {nval_q, hex_d[3:0]};
						pend_n    = 1'b0;
					end
				end
				MODE_ESC: begin
					run_esc = 1'b1;
				end
			endcase

			// Escape format step
			if (run_esc) begin
				unique case (esc_phase)
					PH_IDLE: begin
						if (data_s1.in_byte == CHAR_BSL) begin
							phase_n = PH_AFTER;
							if (data_s1.last) err_n = 1'b1;
						end else begin
							have_byte = 1'b1;
							emit_val  = data_s1.in_byte;
						end
					end
					PH_AFTER: begin
						if (data_s1.in_byte >= CHAR_0 && data_s1.in_byte <= CHAR_3) begin
							acc_n   = data_s1.in_byte - CHAR_0;
							open_n  = 1'b1;
							phase_n = PH_SECOND;
							if (data_s1.last) begin
								have_byte = 1'b1;
								emit_val  = acc_n;
							end
						end else if (data_s1.in_byte == CHAR_BSL) begin
							have_byte = 1'b1;
							emit_val  = CHAR_BSL;
							phase_n   = PH_IDLE;
						end else begin
							err_n = 1'b1;
						end
					end
					PH_SECOND, PH_THIRD: begin
						// Take an octal digit, or close the run on anything else
						if (open_q && data_s1.in_byte >= CHAR_0
							&& data_s1.in_byte <= CHAR_7) begin
							acc_n = {acc_q[4:0], data_s1.in_byte[2:0]};
						end else begin
							open_n = 1'b0;
						end
						if (esc_phase == PH_SECOND) begin
							phase_n = PH_THIRD;
							if (data_s1.last) begin
								have_byte = 1'b1;
								emit_val  = acc_n;
							end
						end else begin
							have_byte = 1'b1;
							emit_val  = acc_n;
							phase_n   = PH_IDLE;
							open_n    = 1'b0;
						end
					end
				endcase
			end
		end
	end

	// Update decode state; the final character returns it to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_FIRST;
			pend_q  <= 1'b0;
			nval_q  <= 4'd0;
			phase_q <= PH_IDLE;
			open_q  <= 1'b0;
			acc_q   <= 8'd0;
			err_q   <= 1'b0;
		end else if (adv) begin
			if (data_s1.last) begin
				mode_q  <= MODE_FIRST;
				pend_q  <= 1'b0;
				nval_q  <= 4'd0;
				phase_q <= PH_IDLE;
				open_q  <= 1'b0;
				acc_q   <= 8'd0;
				err_q   <= 1'b0;
			end else begin
				mode_q  <= mode_n;
				pend_q  <= pend_n;
				nval_q  <= nval_n;
				phase_q <= phase_n;
				open_q  <= open_n;
				acc_q   <= acc_n;
				err_q   <= err_n;
			end
		end
	end

	// Build up to two results: decoded byte first, then the end item
	always_comb begin
		bytd_out_t byte_ent;
		bytd_out_t end_ent;
		byte_ent = '{out_byte: emit_val, is_end: 1'b0, error: 1'b0};
		end_ent  = '{out_byte: 8'd0, is_end: 1'b1, error: err_n};
		ent0     = byte_ent;
		ent1     = end_ent;
		push_cnt = 2'd0;
		if (adv) begin
			priority if (have_byte && !err_n) begin
				push_cnt = data_s1.last ? 2'd2 : 2'd1;
			end else if (data_s1.last) begin
				ent0     = end_ent;
				push_cnt = 2'd1;
			end
		end
	end

	// Output queue
	assign pop        = byte_valid && !byte_stall;
	assign byte_valid = (count_q != '0);
	assign byte_data  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) fifo_q[wr_ptr_q] <= ent0;
		if (push_cnt == 2'd2) fifo_q[wr_ptr_q + PTR_W'(1)] <= ent1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_cnt);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + CNT_W'(push_cnt) - CNT_W'(pop);
		end
	end

	// Queue never overfills
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("output queue overflow");

	// Input stalls only behind a held character
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	// The final character leaves the decoder ready for a new string
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && data_s1.last) |=> (mode_q == MODE_FIRST && !err_q && !pend_q))
		else $error("decode state not cleared after end of string");

	// An error never stands while awaiting the first character
	a_err_mode: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> (mode_q != MODE_FIRST))
		else $error("error flag set at start of string");

	// A finishing character pushes its end item
	a_end_push: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && data_s1.last) |-> (push_cnt != 2'd0))
		else $error("end item not queued");

endmodule
